>>> rtl/core/hpp_pkg.sv
// Shared types, widths and constants of the height-map point projector.
// Used by the channel interfaces and every module under rtl/core.
package hpp_pkg;

    // Default for the MAP_SIDE parameter of the top level
    localparam int MAP_SIDE_DEF = 1024;

    // Field widths of the channels and configuration registers
    localparam int IDX_W     = 10;
    localparam int Z_W       = 16;
    localparam int SCALE_W   = 16;
    localparam int EXT_W     = 16;
    localparam int TRIG_W    = 16;
    localparam int OUT_W     = 24;
    localparam int GAIN_W    = 24;
    localparam int ZB_W      = 18;
    localparam int REG_W     = 32;
    localparam int CFG_IDX_W = 8;

    // Internal datapath widths
    localparam int D_W       = 18;                  // 2*index - (extent - 1)
    localparam int MULP_W    = D_W + SCALE_W + 1;   // full centering product
    localparam int PX_W      = 33;                  // centered coordinate
    localparam int ZSUM_W    = 19;                  // z_bias + z
    localparam int TSUM_W    = TRIG_W + 1;          // tilt sum and difference
    localparam int PROD_W    = PX_W + TRIG_W;       // one rotation product
    localparam int ROT_SUM_W = PROD_W + 1;          // sum of two products
    localparam int ROT_SHIFT = 15;
    localparam int RXY_W     = ROT_SUM_W - ROT_SHIFT;
    localparam int REL_W     = ZSUM_W + GAIN_W;
    localparam int RELT_W    = REL_W + TSUM_W;
    localparam int REL_SHIFT = 22;
    localparam int RELR_W    = RELT_W - REL_SHIFT;
    localparam int SQ_W      = 18;
    localparam int XP_W      = RXY_W + SQ_W;
    localparam int X_SHIFT   = 16;
    localparam int XR_W      = XP_W - X_SHIFT;
    localparam int YP_W      = RXY_W + TSUM_W;
    localparam int Y_SHIFT   = 14;
    localparam int YR_W      = YP_W - Y_SHIFT;
    localparam int SUM_W     = 40;

    // Pipeline depth from acceptance to result register
    localparam int PIPE_DEPTH = 6;
    localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

    // sqrt(2) in Q.16
    localparam logic signed [SQ_W-1:0] SQRT2_Q16 = SQ_W'(92682);

    // Half-LSB rounding offsets
    localparam logic signed [ROT_SUM_W-1:0] RND_ROT = ROT_SUM_W'(1 << (ROT_SHIFT - 1));
    localparam logic signed [RELT_W-1:0]    RND_REL = RELT_W'(1 << (REL_SHIFT - 1));
    localparam logic signed [XP_W-1:0]      RND_X   = XP_W'(1 << (X_SHIFT - 1));
    localparam logic signed [YP_W-1:0]      RND_Y   = YP_W'(1 << (Y_SHIFT - 1));

    // Saturation limits of the Q16.8 outputs
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(256);
    localparam logic [REG_W-1:0]   TRIG_PAIR_RST = 32'h4000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE       = 8'd0,
        REG_ROTATION    = 8'd1,
        REG_TILT        = 8'd2,
        REG_MAP_EXTENT  = 8'd3,
        REG_OFFSET_X    = 8'd4,
        REG_OFFSET_Y    = 8'd5,
        REG_RELIEF_GAIN = 8'd6,
        REG_Z_BIAS      = 8'd7
    } cfg_idx_t;

    // Decoded configuration, fanned out to the datapath
    typedef struct packed {
        logic [SCALE_W-1:0]        scale;
        logic [EXT_W-1:0]          wm1;
        logic [EXT_W-1:0]          hm1;
        logic signed [TRIG_W-1:0]  rot_cos;
        logic signed [TRIG_W-1:0]  rot_sin;
        logic signed [TSUM_W-1:0]  tilt_sum;
        logic signed [TSUM_W-1:0]  tilt_dif;
        logic signed [OUT_W-1:0]   offset_x;
        logic signed [OUT_W-1:0]   offset_y;
        logic signed [GAIN_W-1:0]  relief_gain;
        logic signed [ZB_W-1:0]    z_bias;
    } cfg_t;

    // Centered point handed to the rotation stages
    typedef struct packed {
        logic signed [PX_W-1:0]   px;
        logic signed [PX_W-1:0]   py;
        logic signed [ZSUM_W-1:0] zsum;
    } ctr_t;

    // Rotated point and relief term handed to the projection stages
    typedef struct packed {
        logic signed [RXY_W-1:0]  rx;
        logic signed [RXY_W-1:0]  ry;
        logic signed [RELT_W-1:0] relt;
    } rot_t;

    // Clip a wide sum to the signed output range
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic [OUT_W-1:0] res;
        priority if (v > SAT_MAX)
            res = SAT_MAX[OUT_W-1:0];
        else if (v < SAT_MIN)
            res = SAT_MIN[OUT_W-1:0];
        else
            res = v[OUT_W-1:0];
        return res;
    endfunction

endpackage

>>> rtl/core/hpp_ifs.sv
// Channel interfaces of the height-map point projector: point input,
// screen result and configuration write. Widths come from hpp_pkg.
interface hpp_point_if;
    logic                             valid;
    logic                             ready;
    logic [hpp_pkg::IDX_W-1:0]        grid_col;
    logic [hpp_pkg::IDX_W-1:0]        grid_row;
    logic signed [hpp_pkg::Z_W-1:0]   height_z;

    modport source (output valid, output grid_col, output grid_row, output height_z,
                    input ready);
    modport sink   (input valid, input grid_col, input grid_row, input height_z,
                    output ready);
endinterface

interface hpp_screen_if;
    logic                             valid;
    logic                             ready;
    logic signed [hpp_pkg::OUT_W-1:0] screen_x;
    logic signed [hpp_pkg::OUT_W-1:0] screen_y;

    modport source (output valid, output screen_x, output screen_y, input ready);
    modport sink   (input valid, input screen_x, input screen_y, output ready);
endinterface

interface hpp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hpp_pkg::CFG_IDX_W-1:0]     index;
    logic [hpp_pkg::REG_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/hpp_cfg_regs.sv
// Configuration register file of the point projector; decodes the trig
// pairs and extents for the datapath. Depends on hpp_pkg and hpp_cfg_if.
module hpp_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    hpp_cfg_if.sink       cfg,
    output hpp_pkg::cfg_t cfg_regs
);

    logic [hpp_pkg::SCALE_W-1:0]      scale_reg;
    logic [hpp_pkg::REG_W-1:0]        rotation_reg;
    logic [hpp_pkg::REG_W-1:0]        tilt_reg;
    logic [hpp_pkg::REG_W-1:0]        extent_reg;
    logic [hpp_pkg::OUT_W-1:0]        offset_x_reg;
    logic [hpp_pkg::OUT_W-1:0]        offset_y_reg;
    logic [hpp_pkg::GAIN_W-1:0]       gain_reg;
    logic [hpp_pkg::ZB_W-1:0]         z_bias_reg;
    logic signed [hpp_pkg::TRIG_W-1:0] tilt_cos;
    logic signed [hpp_pkg::TRIG_W-1:0] tilt_sin;

    // Take every write
    assign cfg.ready = 1'b1;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= hpp_pkg::SCALE_RST;
            rotation_reg <= hpp_pkg::TRIG_PAIR_RST;
            tilt_reg     <= hpp_pkg::TRIG_PAIR_RST;
            extent_reg   <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            gain_reg     <= '0;
            z_bias_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (hpp_pkg::cfg_idx_t'(cfg.index))
                hpp_pkg::REG_SCALE:       scale_reg    <= cfg.data[hpp_pkg::SCALE_W-1:0];
                hpp_pkg::REG_ROTATION:    rotation_reg <= cfg.data;
                hpp_pkg::REG_TILT:        tilt_reg     <= cfg.data;
                hpp_pkg::REG_MAP_EXTENT:  extent_reg   <= cfg.data;
                hpp_pkg::REG_OFFSET_X:    offset_x_reg <= cfg.data[hpp_pkg::OUT_W-1:0];
                hpp_pkg::REG_OFFSET_Y:    offset_y_reg <= cfg.data[hpp_pkg::OUT_W-1:0];
                hpp_pkg::REG_RELIEF_GAIN: gain_reg     <= cfg.data[hpp_pkg::GAIN_W-1:0];
                hpp_pkg::REG_Z_BIAS:      z_bias_reg   <= cfg.data[hpp_pkg::ZB_W-1:0];
                default:                  ;
            endcase
        end
    end

    assign tilt_cos = $signed(tilt_reg[hpp_pkg::REG_W-1:hpp_pkg::TRIG_W]);
    assign tilt_sin = $signed(tilt_reg[hpp_pkg::TRIG_W-1:0]);

    // Split the packed pairs and form the tilt sum and difference
    always_comb
    begin
        cfg_regs.scale       = scale_reg;
        cfg_regs.wm1         = extent_reg[hpp_pkg::REG_W-1:hpp_pkg::EXT_W];
        cfg_regs.hm1         = extent_reg[hpp_pkg::EXT_W-1:0];
        cfg_regs.rot_cos     = $signed(rotation_reg[hpp_pkg::REG_W-1:hpp_pkg::TRIG_W]);
        cfg_regs.rot_sin     = $signed(rotation_reg[hpp_pkg::TRIG_W-1:0]);
        cfg_regs.tilt_sum    = {tilt_sin[hpp_pkg::TRIG_W-1], tilt_sin}
                             + {tilt_cos[hpp_pkg::TRIG_W-1], tilt_cos};
        cfg_regs.tilt_dif    = {tilt_cos[hpp_pkg::TRIG_W-1], tilt_cos}
                             - {tilt_sin[hpp_pkg::TRIG_W-1], tilt_sin};
        cfg_regs.offset_x    = $signed(offset_x_reg);
        cfg_regs.offset_y    = $signed(offset_y_reg);
        cfg_regs.relief_gain = $signed(gain_reg);
        cfg_regs.z_bias      = $signed(z_bias_reg);
    end

endmodule

>>> rtl/core/hpp_center.sv
// Stages 1 and 2: clamp the grid index, center it on the map and scale it;
// also form z_bias + z. Depends on hpp_pkg and hpp_point_if.
module hpp_center #(
    parameter int MAP_SIDE = hpp_pkg::MAP_SIDE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  hpp_pkg::cfg_t cfg_regs,
    hpp_point_if.sink     point_in,
    output logic          out_valid,
    input  logic          out_ready,
    output hpp_pkg::ctr_t out_data
);

    localparam int CMP_W = 17;
    localparam logic [CMP_W-1:0] IDX_MAX = CMP_W'(MAP_SIDE - 1);

    logic [hpp_pkg::IDX_W-1:0]             col_c;
    logic [hpp_pkg::IDX_W-1:0]             row_c;
    logic signed [hpp_pkg::D_W-1:0]        dcol_next;
    logic signed [hpp_pkg::D_W-1:0]        drow_next;
    logic signed [hpp_pkg::ZSUM_W-1:0]     zsum_next;
    logic signed [hpp_pkg::MULP_W-1:0]     px_prod;
    logic signed [hpp_pkg::MULP_W-1:0]     py_prod;

    logic                                  s1_valid_reg;
    logic signed [hpp_pkg::D_W-1:0]        s1_dcol_reg;
    logic signed [hpp_pkg::D_W-1:0]        s1_drow_reg;
    logic signed [hpp_pkg::ZSUM_W-1:0]     s1_zsum_reg;
    logic                                  s2_valid_reg;
    logic signed [hpp_pkg::PX_W-1:0]       s2_px_reg;
    logic signed [hpp_pkg::PX_W-1:0]       s2_py_reg;
    logic signed [hpp_pkg::ZSUM_W-1:0]     s2_zsum_reg;
    logic                                  s1_advance;
    logic                                  s2_advance;

    // Advance a stage when it is empty or the next one takes its item
    assign s2_advance     = !s2_valid_reg || out_ready;
    assign s1_advance     = !s1_valid_reg || s2_advance;
    assign point_in.ready = s1_advance;

    // Clamp indexes beyond the map side
    assign col_c = ({{(CMP_W-hpp_pkg::IDX_W){1'b0}}, point_in.grid_col} > IDX_MAX)
                 ? IDX_MAX[hpp_pkg::IDX_W-1:0] : point_in.grid_col;
    assign row_c = ({{(CMP_W-hpp_pkg::IDX_W){1'b0}}, point_in.grid_row} > IDX_MAX)
                 ? IDX_MAX[hpp_pkg::IDX_W-1:0] : point_in.grid_row;

    // 2*index - (extent - 1), both unsigned, result signed
    assign dcol_next = $signed({{(hpp_pkg::D_W-hpp_pkg::IDX_W-1){1'b0}}, col_c, 1'b0})
                     - $signed({{(hpp_pkg::D_W-hpp_pkg::EXT_W){1'b0}}, cfg_regs.wm1});
    assign drow_next = $signed({{(hpp_pkg::D_W-hpp_pkg::IDX_W-1){1'b0}}, row_c, 1'b0})
                     - $signed({{(hpp_pkg::D_W-hpp_pkg::EXT_W){1'b0}}, cfg_regs.hm1});
    assign zsum_next = $signed({cfg_regs.z_bias[hpp_pkg::ZB_W-1], cfg_regs.z_bias})
                     + $signed({{(hpp_pkg::ZSUM_W-hpp_pkg::Z_W){point_in.height_z[hpp_pkg::Z_W-1]}},
                                point_in.height_z});

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_advance)
            s1_valid_reg <= point_in.valid;
    end

    // Stage 1 data
    always_ff @(posedge clk)
    begin
        if (s1_advance && point_in.valid)
        begin
            s1_dcol_reg <= dcol_next;
            s1_drow_reg <= drow_next;
            s1_zsum_reg <= zsum_next;
        end
    end

    // Scale the centered index
    assign px_prod = s1_dcol_reg * $signed({1'b0, cfg_regs.scale});
    assign py_prod = s1_drow_reg * $signed({1'b0, cfg_regs.scale});

    // Stage 2 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_advance)
            s2_valid_reg <= s1_valid_reg;
    end

    // Stage 2 data
    always_ff @(posedge clk)
    begin
        if (s2_advance && s1_valid_reg)
        begin
            s2_px_reg   <= px_prod[hpp_pkg::PX_W-1:0];
            s2_py_reg   <= py_prod[hpp_pkg::PX_W-1:0];
            s2_zsum_reg <= s1_zsum_reg;
        end
    end

    assign out_valid = s2_valid_reg;

    always_comb
    begin
        out_data.px   = s2_px_reg;
        out_data.py   = s2_py_reg;
        out_data.zsum = s2_zsum_reg;
    end

endmodule

>>> rtl/core/hpp_rotate.sv
// Stages 3 and 4: rotate the centered point and build the relief term
// scaled by the tilt difference. Depends on hpp_pkg.
module hpp_rotate (
    input  logic          clk,
    input  logic          rst_n,
    input  hpp_pkg::cfg_t cfg_regs,
    input  logic          in_valid,
    output logic          in_ready,
    input  hpp_pkg::ctr_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output hpp_pkg::rot_t out_data
);

    logic signed [hpp_pkg::PROD_W-1:0]    pxc_next;
    logic signed [hpp_pkg::PROD_W-1:0]    pys_next;
    logic signed [hpp_pkg::PROD_W-1:0]    pxs_next;
    logic signed [hpp_pkg::PROD_W-1:0]    pyc_next;
    logic signed [hpp_pkg::REL_W-1:0]     rel_next;
    logic signed [hpp_pkg::ROT_SUM_W-1:0] sum_x;
    logic signed [hpp_pkg::ROT_SUM_W-1:0] sum_y;
    logic signed [hpp_pkg::ROT_SUM_W-1:0] shr_x;
    logic signed [hpp_pkg::ROT_SUM_W-1:0] shr_y;
    logic signed [hpp_pkg::RELT_W-1:0]    relt_next;

    logic                                 s3_valid_reg;
    logic signed [hpp_pkg::PROD_W-1:0]    s3_pxc_reg;
    logic signed [hpp_pkg::PROD_W-1:0]    s3_pys_reg;
    logic signed [hpp_pkg::PROD_W-1:0]    s3_pxs_reg;
    logic signed [hpp_pkg::PROD_W-1:0]    s3_pyc_reg;
    logic signed [hpp_pkg::REL_W-1:0]     s3_rel_reg;
    logic                                 s4_valid_reg;
    logic signed [hpp_pkg::RXY_W-1:0]     s4_rx_reg;
    logic signed [hpp_pkg::RXY_W-1:0]     s4_ry_reg;
    logic signed [hpp_pkg::RELT_W-1:0]    s4_relt_reg;
    logic                                 s3_advance;
    logic                                 s4_advance;

    assign s4_advance = !s4_valid_reg || out_ready;
    assign s3_advance = !s3_valid_reg || s4_advance;
    assign in_ready   = s3_advance;

    // Four rotation products and the relief product
    assign pxc_next = $signed(in_data.px) * cfg_regs.rot_cos;
    assign pys_next = $signed(in_data.py) * cfg_regs.rot_sin;
    assign pxs_next = $signed(in_data.px) * cfg_regs.rot_sin;
    assign pyc_next = $signed(in_data.py) * cfg_regs.rot_cos;
    assign rel_next = $signed(in_data.zsum) * cfg_regs.relief_gain;

    // Stage 3 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_advance)
            s3_valid_reg <= in_valid;
    end

    // Stage 3 data
    always_ff @(posedge clk)
    begin
        if (s3_advance && in_valid)
        begin
            s3_pxc_reg <= pxc_next;
            s3_pys_reg <= pys_next;
            s3_pxs_reg <= pxs_next;
            s3_pyc_reg <= pyc_next;
            s3_rel_reg <= rel_next;
        end
    end

    // Sum the rotation products, round to Q.8; relief times tilt_dif
    assign sum_x     = s3_pxc_reg - s3_pys_reg + hpp_pkg::RND_ROT;
    assign sum_y     = s3_pxs_reg + s3_pyc_reg + hpp_pkg::RND_ROT;
    assign shr_x     = sum_x >>> hpp_pkg::ROT_SHIFT;
    assign shr_y     = sum_y >>> hpp_pkg::ROT_SHIFT;
    assign relt_next = s3_rel_reg * cfg_regs.tilt_dif;

    // Stage 4 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (s4_advance)
            s4_valid_reg <= s3_valid_reg;
    end

    // Stage 4 data
    always_ff @(posedge clk)
    begin
        if (s4_advance && s3_valid_reg)
        begin
            s4_rx_reg   <= shr_x[hpp_pkg::RXY_W-1:0];
            s4_ry_reg   <= shr_y[hpp_pkg::RXY_W-1:0];
            s4_relt_reg <= relt_next;
        end
    end

    assign out_valid = s4_valid_reg;

    always_comb
    begin
        out_data.rx   = s4_rx_reg;
        out_data.ry   = s4_ry_reg;
        out_data.relt = s4_relt_reg;
    end

endmodule

>>> rtl/core/hpp_project.sv
// Stages 5 and 6: stretch x by sqrt(2), scale y by the tilt sum, add the
// relief term and offsets, and saturate. Depends on hpp_pkg and hpp_screen_if.
module hpp_project (
    input  logic          clk,
    input  logic          rst_n,
    input  hpp_pkg::cfg_t cfg_regs,
    input  logic          in_valid,
    output logic          in_ready,
    input  hpp_pkg::rot_t in_data,
    hpp_screen_if.source  screen_out
);

    logic signed [hpp_pkg::XP_W-1:0]   xp_next;
    logic signed [hpp_pkg::YP_W-1:0]   yp_next;
    logic signed [hpp_pkg::RELT_W-1:0] relt_rnd;
    logic signed [hpp_pkg::RELT_W-1:0] relt_shr;
    logic signed [hpp_pkg::XP_W-1:0]   x_shr;
    logic signed [hpp_pkg::YP_W-1:0]   y_shr;
    logic signed [hpp_pkg::SUM_W-1:0]  x_sum;
    logic signed [hpp_pkg::SUM_W-1:0]  y_sum;

    logic                              s5_valid_reg;
    logic signed [hpp_pkg::XP_W-1:0]   s5_xp_reg;
    logic signed [hpp_pkg::YP_W-1:0]   s5_yp_reg;
    logic signed [hpp_pkg::RELR_W-1:0] s5_relr_reg;
    logic                              s6_valid_reg;
    logic [hpp_pkg::OUT_W-1:0]         s6_x_reg;
    logic [hpp_pkg::OUT_W-1:0]         s6_y_reg;
    logic                              s5_advance;
    logic                              s6_advance;

    assign s6_advance = !s6_valid_reg || screen_out.ready;
    assign s5_advance = !s5_valid_reg || s6_advance;
    assign in_ready   = s5_advance;

    // Projection products; round the relief term to Q.8
    assign xp_next  = $signed(in_data.rx) * hpp_pkg::SQRT2_Q16;
    assign yp_next  = $signed(in_data.ry) * cfg_regs.tilt_sum;
    assign relt_rnd = $signed(in_data.relt) + hpp_pkg::RND_REL;
    assign relt_shr = relt_rnd >>> hpp_pkg::REL_SHIFT;

    // Stage 5 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (s5_advance)
            s5_valid_reg <= in_valid;
    end

    // Stage 5 data
    always_ff @(posedge clk)
    begin
        if (s5_advance && in_valid)
        begin
            s5_xp_reg   <= xp_next;
            s5_yp_reg   <= yp_next;
            s5_relr_reg <= relt_shr[hpp_pkg::RELR_W-1:0];
        end
    end

    // Round, add offsets and relief, then clip
    assign x_shr = (s5_xp_reg + hpp_pkg::RND_X) >>> hpp_pkg::X_SHIFT;
    assign y_shr = (s5_yp_reg + hpp_pkg::RND_Y) >>> hpp_pkg::Y_SHIFT;
    assign x_sum = $signed(x_shr[hpp_pkg::XR_W-1:0]) + cfg_regs.offset_x;
    assign y_sum = $signed(y_shr[hpp_pkg::YR_W-1:0]) + s5_relr_reg + cfg_regs.offset_y;

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (s6_advance)
            s6_valid_reg <= s5_valid_reg;
    end

    // Result register data
    always_ff @(posedge clk)
    begin
        if (s6_advance && s5_valid_reg)
        begin
            s6_x_reg <= hpp_pkg::sat_out(x_sum);
            s6_y_reg <= hpp_pkg::sat_out(y_sum);
        end
    end

    assign screen_out.valid    = s6_valid_reg;
    assign screen_out.screen_x = $signed(s6_x_reg);
    assign screen_out.screen_y = $signed(s6_y_reg);

endmodule

>>> rtl/core/heightmap_point_projection.sv
// Height-map point projector: an accepted point is registered in each stage
// up to a valid screen point; one point per cycle unless the output stalls.
// Depth is set by the multiplier chain: scale, rotation, then sqrt(2)/tilt,
// each in its own stage. A stalled output holds all six stages full; a
// bubble is refilled at once. Reset clears every stage valid bit and loads
// the register reset values; the configuration channel is always ready.
module heightmap_point_projection #(
    parameter int MAP_SIDE = hpp_pkg::MAP_SIDE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    hpp_cfg_if.sink      cfg,
    hpp_point_if.sink    point_in,
    hpp_screen_if.source screen_out
);

    hpp_pkg::cfg_t              cfg_regs;
    hpp_pkg::ctr_t              ctr_data;
    hpp_pkg::rot_t              rot_data;
    logic                       ctr_valid;
    logic                       ctr_ready;
    logic                       rot_valid;
    logic                       rot_ready;
    logic                       in_acc;
    logic                       out_acc;
    logic                       flow_ok;
    logic [hpp_pkg::OCC_W-1:0]  occ_reg;
    logic [hpp_pkg::OCC_W-1:0]  occ_next;

    hpp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    hpp_center #(
        .MAP_SIDE (MAP_SIDE)
    ) u_center (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs),
        .point_in  (point_in),
        .out_valid (ctr_valid),
        .out_ready (ctr_ready),
        .out_data  (ctr_data)
    );

    hpp_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs),
        .in_valid  (ctr_valid),
        .in_ready  (ctr_ready),
        .in_data   (ctr_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    hpp_project u_project (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_regs),
        .in_valid   (rot_valid),
        .in_ready   (rot_ready),
        .in_data    (rot_data),
        .screen_out (screen_out)
    );

    // Track points in flight for the checks below
    assign in_acc  = point_in.valid && point_in.ready && rst_n;
    assign out_acc = screen_out.valid && screen_out.ready;
    assign flow_ok = screen_out.ready && rst_n;

    always_comb
    begin
        priority if (in_acc && !out_acc)
            occ_next = occ_reg + hpp_pkg::OCC_W'(1);
        else if (!in_acc && out_acc)
            occ_next = occ_reg - hpp_pkg::OCC_W'(1);
        else
            occ_next = occ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // Never more points in flight than stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= hpp_pkg::OCC_W'(hpp_pkg::PIPE_DEPTH))
        else $error("more points in flight than pipeline stages");

    // A result is only shown for a point that entered
    a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        screen_out.valid |-> occ_reg != '0)
        else $error("screen point shown with no point in flight");

    // Input backpressure only when every stage holds a point
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !point_in.ready |-> occ_reg == hpp_pkg::OCC_W'(hpp_pkg::PIPE_DEPTH))
        else $error("input stalled while a stage is empty");

    // With the output draining, a point appears after the pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(in_acc, 6) && $past(flow_ok, 5) && $past(flow_ok, 4)
         && $past(flow_ok, 3) && $past(flow_ok, 2) && $past(flow_ok, 1))
        |-> screen_out.valid)
        else $error("screen point missing after pipeline latency");

endmodule
